// ----- rtl/klle_pkg.sv -----
// package for the keyed linked list engine
// request kinds, status codes and default sizes; no dependencies
package klle_pkg;
    localparam int NODES_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        K_APPEND = 3'd0,
        K_INS_AFTER = 3'd1,
        K_INS_BEFORE = 3'd2,
        K_REM_FIRST = 3'd3,
        K_REM_LAST = 3'd4,
        K_REM_AFTER = 3'd5,
        K_REM_BEFORE = 3'd6,
        K_NOP = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        S_OK = 3'd0,
        S_EMPTY = 3'd1,
        S_NOT_FOUND = 3'd2,
        S_NO_NEIGHBOR = 3'd3,
        S_FULL = 3'd4
    } t_status;
endpackage

// ----- rtl/klle_seq.sv -----
// sequencer and node pool of the keyed linked list engine
// depends on klle_pkg; link and value memories live here
module klle_seq import klle_pkg::*; #(
    parameter int NODES = NODES_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_kind                 i_kind,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_busy,
    output logic                  o_done,
    output t_status               o_status,
    output logic [DATA_WIDTH-1:0] o_removed
);
    localparam int PW = $clog2(NODES + 1);
    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [PW-1:0] NIL = PW'(NODES);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_INIT   = 11'b00000000010,
        ST_SRCH   = 11'b00000000100,
        ST_SRCHW  = 11'b00000001000,
        ST_DISP   = 11'b00000010000,
        ST_LNK    = 11'b00000100000,
        ST_LNK2   = 11'b00001000000,
        ST_ULRD   = 11'b00010000000,
        ST_ULW    = 11'b00100000000,
        ST_ULW2   = 11'b01000000000,
        ST_DONE   = 11'b10000000000
    } t_state;

    logic [DATA_WIDTH-1:0] r_val [NODES];
    logic [PW-1:0]         r_nxt [NODES];
    logic [PW-1:0]         r_prv [NODES];

    t_state r_st;
    t_kind  r_kind;
    logic [DATA_WIDTH-1:0] r_key, r_value, r_rem;
    logic [PW-1:0] r_head, r_tail, r_free, r_p, r_t, r_n, r_pp, r_init;
    logic [PW:0]   r_steps;
    t_status r_status;
    logic [DATA_WIDTH-1:0] r_rdv;
    logic [PW-1:0] r_rdn, r_rdp, r_rdfn;

    logic [AW-1:0] w_pa;
    assign w_pa = r_p[AW-1:0];

    // registered read ports: value, next and back link addressed from r_p, next link also from r_free
    always_ff @(posedge i_clk) begin
        if (r_p != NIL) begin
            r_rdv <= r_val[w_pa];
            r_rdn <= r_nxt[w_pa];
            r_rdp <= r_prv[w_pa];
        end
        if (r_free != NIL) begin
            r_rdfn <= r_nxt[r_free[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_INIT;
            r_init <= '0;
            r_head <= NIL;
            r_tail <= NIL;
            r_free <= '0;
            r_p <= NIL;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_st)
                ST_INIT: begin
                    r_nxt[r_init[AW-1:0]] <= r_init + PW'(1);
                    r_prv[r_init[AW-1:0]] <= NIL;
                    r_init <= r_init + PW'(1);
                    if (r_init == NIL - PW'(1)) r_st <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_start) begin
                        r_kind <= i_kind;
                        r_key <= i_key;
                        r_value <= i_value;
                        r_rem <= '0;
                        r_status <= S_OK;
                        r_steps <= '0;
                        if (i_kind == K_NOP) r_st <= ST_DONE;
                        else if (i_kind == K_APPEND) begin
                            r_p <= r_tail;
                            r_st <= (r_free == NIL) ? ST_DONE : ST_SRCHW;
                            if (r_free == NIL) r_status <= S_FULL;
                        end else if (r_head == NIL) begin
                            r_status <= S_EMPTY;
                            r_st <= ST_DONE;
                        end else if (i_kind == K_REM_FIRST) begin
                            r_p <= r_head;
                            r_st <= ST_ULRD;
                        end else if (i_kind == K_REM_LAST) begin
                            r_p <= (r_tail != NIL) ? r_tail : r_head;
                            r_st <= ST_ULRD;
                        end else begin
                            r_p <= r_head;
                            r_st <= ST_SRCH;
                        end
                    end
                end
                ST_SRCH: r_st <= ST_SRCHW;
                ST_SRCHW: begin
                    if (r_kind == K_APPEND) begin
                        r_t <= r_free;
                        r_pp <= r_tail;
                        r_n <= NIL;
                        r_st <= ST_LNK;
                    end else if (r_rdv == r_key) begin
                        r_st <= ST_DISP;
                    end else if (r_rdn == NIL || r_steps + 1'b1 >= (PW+1)'(NODES)) begin
                        r_status <= S_NOT_FOUND;
                        r_st <= ST_DONE;
                    end else begin
                        r_p <= r_rdn;
                        r_steps <= r_steps + 1'b1;
                        r_st <= ST_SRCH;
                    end
                end
                ST_DISP: begin
                    if (r_kind == K_INS_AFTER || r_kind == K_INS_BEFORE) begin
                        if (r_free == NIL) begin
                            r_status <= S_FULL;
                            r_st <= ST_DONE;
                        end else begin
                            r_t <= r_free;
                            r_pp <= (r_kind == K_INS_AFTER) ? r_p : r_rdp;
                            r_n <= (r_kind == K_INS_AFTER) ? r_rdn : r_p;
                            r_st <= ST_LNK;
                        end
                    end else begin
                        if (((r_kind == K_REM_AFTER) ? r_rdn : r_rdp) == NIL) begin
                            r_status <= S_NO_NEIGHBOR;
                            r_st <= ST_DONE;
                        end else begin
                            r_p <= (r_kind == K_REM_AFTER) ? r_rdn : r_rdp;
                            r_st <= ST_ULRD;
                        end
                    end
                end
                ST_LNK: begin
                    r_free <= r_rdfn;
                    r_val[r_t[AW-1:0]] <= r_value;
                    r_nxt[r_t[AW-1:0]] <= r_n;
                    r_prv[r_t[AW-1:0]] <= r_pp;
                    if (r_pp != NIL) r_nxt[r_pp[AW-1:0]] <= r_t;
                    else r_head <= r_t;
                    r_st <= ST_LNK2;
                end
                ST_LNK2: begin
                    if (r_n != NIL) r_prv[r_n[AW-1:0]] <= r_t;
                    else r_tail <= r_t;
                    r_st <= ST_DONE;
                end
                ST_ULRD: r_st <= ST_ULW;
                ST_ULW: begin
                    r_rem <= r_rdv;
                    if (r_rdp != NIL) r_nxt[r_rdp[AW-1:0]] <= r_rdn;
                    else r_head <= r_rdn;
                    r_nxt[w_pa] <= r_free;
                    r_prv[w_pa] <= NIL;
                    r_free <= r_p;
                    r_st <= ST_ULW2;
                end
                ST_ULW2: begin
                    if (r_rdn != NIL) r_prv[r_rdn[AW-1:0]] <= r_rdp;
                    else r_tail <= r_rdp;
                    r_st <= ST_DONE;
                end
                ST_DONE: begin
                    o_done <= 1'b1;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = (r_st != ST_IDLE);
    assign o_status = r_status;
    assign o_removed = r_rem;
endmodule

// ----- rtl/keyed_linked_list_engine.sv -----
// keyed linked list engine: ordered list in a node pool with a free list
// a NOP, an empty list or an append to a full pool end without touching the list;
// keyed kinds first search the list from the head, node by node
// throughput: one item at a time; the next is accepted once the result item is taken
// reset: synchronous active low, then an init pass over all NODES nodes chains the free list
// and clears back links; no item is accepted during that pass
// depends on klle_pkg and klle_seq
module keyed_linked_list_engine import klle_pkg::*; #(
    parameter int NODES = NODES_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // kind[2:0], key[34:3], value[66:35], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // status[2:0], removed_value[34:3], zero fill
);
    logic busy, done, r_ov;
    t_status st;
    logic [DATA_WIDTH-1:0] rem;
    logic [31:0] rem32;
    logic [2:0] r_s;
    logic [31:0] r_r;

    assign s_axis_tready = !busy && !r_ov && !done;

    klle_seq #(.NODES(NODES), .DATA_WIDTH(DATA_WIDTH)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && s_axis_tready),
        .i_kind(t_kind'(s_axis_tdata[2:0])),
        .i_key(DATA_WIDTH'(signed'(s_axis_tdata[34:3]))),
        .i_value(DATA_WIDTH'(signed'(s_axis_tdata[66:35]))),
        .o_busy(busy), .o_done(done), .o_status(st), .o_removed(rem)
    );

    assign rem32 = 32'(signed'(rem));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (done) r_ov <= 1'b1;
        else if (m_axis_tready) r_ov <= 1'b0;
        if (done) begin
            r_s <= st;
            r_r <= rem32;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {5'd0, r_r, r_s};
endmodule

// ----- bench/tb.sv -----
// testbench for the keyed linked list engine: random and directed list requests
// checked against a behavioral list model kept in the bench; depends on klle_pkg and keyed_linked_list_engine
`timescale 1ns / 100ps

module tb import klle_pkg::*;;

    localparam int N = 64;
    localparam int NIL = N;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] removed;
    } rsp_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    keyed_linked_list_engine uut (.*);

    always #5 i_clk = ~i_clk;

    // list model
    logic [31:0] lst_val [N];
    int          lst_nxt [N];
    int          lst_prv [N];
    int          head, tail, free_head, used;

    req_t pending [$];
    rsp_t expected [$];
    int   errors = 0;
    bit   stim_done = 0;

    function automatic int find_first(logic [31:0] k);
        int p;
        p = head;
        while (p != NIL) begin
            if (lst_val[p] == k) return p;
            p = lst_nxt[p];
        end
        return NIL;
    endfunction

    function automatic int grab(logic [31:0] v);
        int t;
        t = free_head;
        if (t == NIL) return NIL;
        free_head = lst_nxt[t];
        lst_val[t] = v;
        used++;
        return t;
    endfunction

    function automatic void splice(int t, int p, int n);
        lst_prv[t] = p;
        lst_nxt[t] = n;
        if (p != NIL) lst_nxt[p] = t; else head = t;
        if (n != NIL) lst_prv[n] = t; else tail = t;
    endfunction

    function automatic logic [31:0] cut(int i);
        int p, n;
        p = lst_prv[i];
        n = lst_nxt[i];
        if (p != NIL) lst_nxt[p] = n; else head = n;
        if (n != NIL) lst_prv[n] = p; else tail = p;
        lst_nxt[i] = free_head;
        lst_prv[i] = NIL;
        free_head = i;
        used--;
        return lst_val[i];
    endfunction

    function automatic rsp_t list_apply(req_t r);
        rsp_t o;
        int p, t;
        o.status = S_OK;
        o.removed = '0;
        case (r.kind)
            K_NOP: ;
            K_APPEND: begin
                t = grab(r.value);
                if (t == NIL) o.status = S_FULL;
                else splice(t, tail, NIL);
            end
            default: begin
                if (head == NIL) o.status = S_EMPTY;
                else if (r.kind == K_REM_FIRST) o.removed = cut(head);
                else if (r.kind == K_REM_LAST) o.removed = cut(tail);
                else begin
                    p = find_first(r.key);
                    if (p == NIL) o.status = S_NOT_FOUND;
                    else if (r.kind == K_INS_AFTER || r.kind == K_INS_BEFORE) begin
                        t = grab(r.value);
                        if (t == NIL) o.status = S_FULL;
                        else if (r.kind == K_INS_AFTER) splice(t, p, lst_nxt[p]);
                        else splice(t, lst_prv[p], p);
                    end else begin
                        t = (r.kind == K_REM_AFTER) ? lst_nxt[p] : lst_prv[p];
                        if (t == NIL) o.status = S_NO_NEIGHBOR;
                        else o.removed = cut(t);
                    end
                end
            end
        endcase
        return o;
    endfunction

    // keys mostly drawn from values already in the list, else from a small pool or at random, so most searches hit
    function automatic logic [31:0] pick_key();
        int p, n;
        if (head != NIL && $urandom_range(0, 9) < 8) begin
            n = $urandom_range(0, used - 1);
            p = head;
            repeat (n) p = lst_nxt[p];
            return lst_val[p];
        end
        return (($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 15)));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'h8000_0000 | 32'($urandom_range(0, 3));
            default: return 32'($urandom_range(0, 15));
        endcase
    endfunction

    // driver
    int   src_wait = 0;
    req_t cur;
    bit   in_acc = 0;

    always @(posedge i_clk) begin
        in_acc <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_acc) begin
                expected.push_back(list_apply(cur));
                src_wait = $urandom_range(0, 4);
                if (pending.size() > 0 && src_wait == 0) begin
                    cur = pending.pop_front();
                    s_axis_tdata <= {5'd0, cur.value, cur.key, cur.kind};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end else if (!s_axis_tvalid && pending.size() > 0) begin
                if (src_wait > 0) src_wait--;
                else begin
                    cur = pending.pop_front();
                    s_axis_tdata <= {5'd0, cur.value, cur.key, cur.kind};
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // sink stall
    int snk_wait = 0;

    always @(negedge i_clk) begin
        if (snk_wait > 0) begin
            snk_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rsp_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tdata[2:0]);
            got.removed = m_axis_tdata[34:3];
            snk_wait = $urandom_range(0, 4);
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: status %0d value %h",
                                           got.status, got.removed);
            end else begin
                want = expected.pop_front();
                if (got.status !== want.status || got.removed !== want.removed) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                                 want.status, got.status, want.removed, got.removed);
                end
            end
        end
    end

    // stimulus: generated while the model advances, so keys follow the list contents
    function automatic req_t mk(t_kind k, logic [31:0] key, logic [31:0] v);
        req_t r;
        r.kind = k;
        r.key = key;
        r.value = v;
        return r;
    endfunction

    initial begin
        req_t r;
        int   phase_len, bias;
        for (int i = 0; i < N; i++) begin
            lst_nxt[i] = i + 1;
            lst_prv[i] = NIL;
        end
        head = NIL;
        tail = NIL;
        free_head = 0;
        used = 0;
        cur = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: empty list cases, extremes, each kind
        pending.push_back(mk(K_REM_FIRST, 0, 0));
        pending.push_back(mk(K_REM_LAST, 0, 0));
        pending.push_back(mk(K_INS_AFTER, 0, 1));
        pending.push_back(mk(K_REM_BEFORE, 0, 0));
        pending.push_back(mk(K_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending.push_back(mk(K_APPEND, 0, 32'h8000_0000));
        pending.push_back(mk(K_APPEND, 0, 32'h7FFF_FFFF));
        pending.push_back(mk(K_INS_AFTER, 32'h8000_0000, 32'hFFFF_FFFF));
        pending.push_back(mk(K_INS_BEFORE, 32'h8000_0000, 0));
        pending.push_back(mk(K_INS_BEFORE, 5, 5));
        pending.push_back(mk(K_REM_BEFORE, 0, 0));
        pending.push_back(mk(K_REM_AFTER, 32'h7FFF_FFFF, 0));
        pending.push_back(mk(K_REM_AFTER, 32'hFFFF_FFFF, 0));
        pending.push_back(mk(K_REM_BEFORE, 32'h8000_0000, 0));
        pending.push_back(mk(K_REM_LAST, 0, 0));
        pending.push_back(mk(K_REM_FIRST, 0, 0));
        pending.push_back(mk(K_REM_FIRST, 0, 0));
        // fill the pool past full
        for (int i = 0; i < N + 2; i++) pending.push_back(mk(K_APPEND, 0, 32'(i)));
        pending.push_back(mk(K_INS_AFTER, 3, 9));
        pending.push_back(mk(K_INS_BEFORE, 3, 9));
        wait (pending.size() == 0 && expected.size() == 0);

        // random: phases lean toward growing or shrinking the list
        for (int n = 0; n < 1500; n++) begin
            if (n % 100 == 0) bias = $urandom_range(0, 2);
            wait (pending.size() == 0 && !s_axis_tvalid && expected.size() == 0);
            case ($urandom_range(0, 9) + bias)
                0, 1, 2: r.kind = K_APPEND;
                3: r.kind = K_INS_AFTER;
                4: r.kind = K_INS_BEFORE;
                5: r.kind = K_REM_AFTER;
                6: r.kind = K_REM_BEFORE;
                7: r.kind = K_REM_FIRST;
                8: r.kind = ($urandom_range(0, 7) == 0) ? K_NOP : K_REM_LAST;
                default: r.kind = t_kind'($urandom_range(3, 6));
            endcase
            r.key = pick_key();
            r.value = pick_value();
            pending.push_back(r);
            @(negedge i_clk);
        end
        wait (pending.size() == 0 && !s_axis_tvalid);
        wait (expected.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("[keyed_linked_list_engine] OK");
        else $display("[keyed_linked_list_engine] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[keyed_linked_list_engine] ERROR");
        $finish;
    end
endmodule
